// ----- design/pcc_pkg.sv -----
// Shared types, codes and constants for the palette color converter.
package pcc_pkg;

  localparam int unsigned NUM_LANES = 3;   // red, green, blue
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  localparam int unsigned SCL_W  = 9;      // scaled component, 0..273
  localparam int unsigned SUM_W  = 11;     // signed, after brightness offset
  localparam int unsigned MAG_W  = 11;     // component magnitude, up to 1091
  localparam int unsigned C_W    = 9;      // magnitude ahead of contrast, up to 428
  localparam int unsigned PROD_W = 17;     // magnitude times contrast
  localparam int unsigned A_W    = 21;     // magnitude times luma weight
  localparam int unsigned Q_W    = 10;     // luma term, up to 640
  localparam int unsigned V_W    = 12;     // signed component at the output stage

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAYSCALE_ON = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_ON    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_METHOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_PALETTE = 3'd6;

  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_SHADOW    = 2'd1;
  localparam logic [1:0] MODE_HIGHLIGHT = 2'd2;

  localparam logic [1:0] SCALE_RAW = 2'd0;
  localparam logic [1:0] SCALE_224 = 2'd1;
  localparam logic [1:0] SCALE_240 = 2'd2;

  localparam logic [1:0] FMT_RGB555 = 2'd0;
  localparam logic [1:0] FMT_RGB565 = 2'd1;
  localparam logic [1:0] FMT_RGB888 = 2'd2;

  localparam logic [11:0] MASK_FULL  = 12'hEEE;
  localparam logic [11:0] MASK_SMALL = 12'h222;
  localparam logic [11:0] HL_OR      = 12'h888;
  localparam logic [11:0] HL_SUB     = 12'h111;

  localparam logic [SUM_W-1:0] BRIGHT_BIAS = 11'd100;

  // floor(x/100) = (x * RECIP100) >> 24 for x below 2^17
  localparam logic [17:0] RECIP100    = 18'd167773;
  localparam int unsigned RECIP100_SH = 24;
  // floor(x/1000) = (x * RECIP1000) >> 30 for x below 2^20
  localparam logic [20:0] RECIP1000    = 21'd1073742;
  localparam int unsigned RECIP1000_SH = 30;
  localparam logic [A_W-1:0] DIV1000   = 21'd1000;
  localparam logic [A_W-1:0] HALF1000  = 21'd500;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] contrast;
    logic       grayscale_on;
    logic       invert_on;
    logic [1:0] scale_method;
    logic [1:0] pixel_format;
    logic       full_palette;
  } cfg_t;

  // sign and magnitude of one color component
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } comp_t;

  // nibble scaled by the chosen method: shifted left by four (raw) or stretched by 255/224 or 255/240
  function automatic logic [SCL_W-1:0] scale_nibble(input logic [3:0] nib,
                                                    input logic [1:0] method);
    logic [SCL_W-1:0] res;
    res = '0;
    if (method == SCALE_RAW) begin
      res = {1'b0, nib, 4'b0000};
    end else if (method == SCALE_224) begin
      // floor(nib * 16 * 255 / 224)
      case (nib)
        4'd0:  res = 9'd0;
        4'd1:  res = 9'd18;
        4'd2:  res = 9'd36;
        4'd3:  res = 9'd54;
        4'd4:  res = 9'd72;
        4'd5:  res = 9'd91;
        4'd6:  res = 9'd109;
        4'd7:  res = 9'd127;
        4'd8:  res = 9'd145;
        4'd9:  res = 9'd163;
        4'd10: res = 9'd182;
        4'd11: res = 9'd200;
        4'd12: res = 9'd218;
        4'd13: res = 9'd236;
        4'd14: res = 9'd255;
        4'd15: res = 9'd273;
        default: res = '0;
      endcase
    end else begin
      // nib * 16 * 255 / 240 is exactly nib * 17
      res = {1'b0, nib, nib};
    end
    return res;
  endfunction

  // BT.601 weights in thousandths
  function automatic logic [9:0] luma_weight(input int unsigned lane);
    logic [9:0] w;
    case (lane)
      0:       w = 10'd299;
      1:       w = 10'd587;
      default: w = 10'd114;
    endcase
    return w;
  endfunction

endpackage

// ----- design/pcc_expand.sv -----
// Stage one: palette mask, shadow/highlight, nibble scaling and brightness offset.
module pcc_expand (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [11:0]                                color_word_i,
  input  logic [1:0]                                 mode_i,
  input  pcc_pkg::cfg_t                              cfg_i,
  output logic                                       valid_o,
  output pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]    comp_o
);

  logic [11:0]                                   masked;
  logic [11:0]                                   word;
  logic [pcc_pkg::SCL_W-1:0]                     scaled [pcc_pkg::NUM_LANES];
  logic signed [pcc_pkg::SUM_W-1:0]              sum    [pcc_pkg::NUM_LANES];
  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]       comp_d;
  logic                                          valid_q;
  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]       comp_q;

  always_comb begin
    masked = color_word_i & (cfg_i.full_palette ? pcc_pkg::MASK_FULL : pcc_pkg::MASK_SMALL);
    case (mode_i)
      pcc_pkg::MODE_SHADOW:    word = masked >> 1;
      // no nibble borrows: every nibble is at least 8 before the subtract
      pcc_pkg::MODE_HIGHLIGHT: word = ((masked >> 1) | pcc_pkg::HL_OR) - pcc_pkg::HL_SUB;
      default:                 word = masked;
    endcase
  end

  always_comb begin
    for (int i = 0; i < pcc_pkg::NUM_LANES; i++) begin
      scaled[i] = pcc_pkg::scale_nibble(word[4*i +: 4], cfg_i.scale_method);
      sum[i]    = $signed({2'b00, scaled[i]}) + $signed({3'b000, cfg_i.brightness})
                - $signed(pcc_pkg::BRIGHT_BIAS);
      comp_d[i].neg = sum[i][pcc_pkg::SUM_W-1];
      comp_d[i].mag = sum[i][pcc_pkg::SUM_W-1] ? pcc_pkg::MAG_W'(-sum[i])
                                               : pcc_pkg::MAG_W'(sum[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      comp_q <= comp_d;
    end
  end

  assign valid_o = valid_q;
  assign comp_o  = comp_q;

endmodule

// ----- design/pcc_contrast.sv -----
// Contrast: magnitude times contrast, then divide by 100 by reciprocal multiply.
module pcc_contrast (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]    comp_i,
  input  pcc_pkg::cfg_t                              cfg_i,
  output logic                                       valid_o,
  output pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]    comp_o
);

  localparam int unsigned RP_W = pcc_pkg::PROD_W + 18;

  logic [pcc_pkg::PROD_W-1:0]                prod_d [pcc_pkg::NUM_LANES];
  logic [pcc_pkg::PROD_W-1:0]                prod_q [pcc_pkg::NUM_LANES];
  logic [pcc_pkg::NUM_LANES-1:0]             neg_q;
  logic [RP_W-1:0]                           recip  [pcc_pkg::NUM_LANES];
  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]   quo_d;
  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]   quo_q;
  logic                                      vld_p_q;
  logic                                      vld_d_q;

  always_comb begin
    for (int i = 0; i < pcc_pkg::NUM_LANES; i++) begin
      prod_d[i] = pcc_pkg::PROD_W'(comp_i[i].mag[pcc_pkg::C_W-1:0])
                * pcc_pkg::PROD_W'(cfg_i.contrast);
    end
  end

  // truncation toward zero: divide the magnitude, keep the sign
  always_comb begin
    for (int i = 0; i < pcc_pkg::NUM_LANES; i++) begin
      recip[i]     = RP_W'(prod_q[i]) * RP_W'(pcc_pkg::RECIP100);
      quo_d[i].neg = neg_q[i];
      quo_d[i].mag = recip[i][pcc_pkg::RECIP100_SH +: pcc_pkg::MAG_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_p_q <= valid_i;
      vld_d_q <= vld_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < pcc_pkg::NUM_LANES; i++) begin
        prod_q[i] <= prod_d[i];
        neg_q[i]  <= comp_i[i].neg;
      end
      quo_q <= quo_d;
    end
  end

  assign valid_o = vld_d_q;
  assign comp_o  = quo_q;

endmodule

// ----- design/pcc_gray.sv -----
// BT.601 luma terms: weight multiply, divide by 1000, round half to even.
module pcc_gray (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]    comp_i,
  output logic                                       valid_o,
  output pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]    comp_o,
  output logic [pcc_pkg::NUM_LANES-1:0][pcc_pkg::Q_W-1:0] term_o
);

  localparam int unsigned RP_W = 2 * pcc_pkg::A_W;

  logic [pcc_pkg::A_W-1:0]                   wprod_d [pcc_pkg::NUM_LANES];
  logic [pcc_pkg::A_W-1:0]                   wprod_a_q [pcc_pkg::NUM_LANES];
  logic [pcc_pkg::A_W-1:0]                   wprod_b_q [pcc_pkg::NUM_LANES];
  logic [RP_W-1:0]                           recip   [pcc_pkg::NUM_LANES];
  logic [pcc_pkg::Q_W-1:0]                   quo_q   [pcc_pkg::NUM_LANES];
  logic [pcc_pkg::A_W-1:0]                   rem     [pcc_pkg::NUM_LANES];
  logic [pcc_pkg::NUM_LANES-1:0]             rnd_up;
  logic [pcc_pkg::NUM_LANES-1:0][pcc_pkg::Q_W-1:0] term_d;
  logic [pcc_pkg::NUM_LANES-1:0][pcc_pkg::Q_W-1:0] term_q;
  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]   comp_a_q;
  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]   comp_b_q;
  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]   comp_c_q;
  logic                                      vld_a_q;
  logic                                      vld_b_q;
  logic                                      vld_c_q;

  always_comb begin
    for (int i = 0; i < pcc_pkg::NUM_LANES; i++) begin
      wprod_d[i] = pcc_pkg::A_W'(comp_i[i].mag)
                 * pcc_pkg::A_W'(pcc_pkg::luma_weight(i));
      recip[i]   = RP_W'(wprod_a_q[i]) * RP_W'(pcc_pkg::RECIP1000);
    end
  end

  // remainder decides rounding; an exact half goes to the even quotient
  always_comb begin
    for (int i = 0; i < pcc_pkg::NUM_LANES; i++) begin
      rem[i]    = wprod_b_q[i] - (pcc_pkg::A_W'(quo_q[i]) * pcc_pkg::DIV1000);
      rnd_up[i] = (rem[i] > pcc_pkg::HALF1000)
               || ((rem[i] == pcc_pkg::HALF1000) && quo_q[i][0]);
      term_d[i] = quo_q[i] + pcc_pkg::Q_W'(rnd_up[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < pcc_pkg::NUM_LANES; i++) begin
        wprod_a_q[i] <= wprod_d[i];
        wprod_b_q[i] <= wprod_a_q[i];
        quo_q[i]     <= recip[i][pcc_pkg::RECIP1000_SH +: pcc_pkg::Q_W];
      end
      term_q   <= term_d;
      comp_a_q <= comp_i;
      comp_b_q <= comp_a_q;
      comp_c_q <= comp_b_q;
    end
  end

  assign valid_o = vld_c_q;
  assign comp_o  = comp_c_q;
  assign term_o  = term_q;

endmodule

// ----- design/pcc_pack.sv -----
// Output stage: gray sum, invert, depth reduction with clamp, packing.
module pcc_pack (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]    comp_i,
  input  logic [pcc_pkg::NUM_LANES-1:0][pcc_pkg::Q_W-1:0] term_i,
  input  pcc_pkg::cfg_t                              cfg_i,
  output logic                                       valid_o,
  output logic [23:0]                                pixel_o
);

  logic signed [pcc_pkg::V_W-1:0]  luma;
  logic signed [pcc_pkg::V_W-1:0]  val [pcc_pkg::NUM_LANES];
  logic [3:0]                      bits_r;
  logic [3:0]                      bits_g;
  logic [3:0]                      bits_b;
  logic [7:0]                      red;
  logic [7:0]                      green;
  logic [7:0]                      blue;
  logic [23:0]                     pixel_d;
  logic [23:0]                     pixel_q;
  logic                            valid_q;

  function automatic logic signed [pcc_pkg::V_W-1:0] signed_val(input logic neg,
      input logic [pcc_pkg::MAG_W-1:0] mag);
    logic signed [pcc_pkg::V_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // negative clamps to zero, too large clamps to the field maximum
  function automatic logic [7:0] reduce(input logic signed [pcc_pkg::V_W-1:0] v,
                                        input logic [3:0] bits);
    logic [pcc_pkg::V_W-2:0] u;
    logic [pcc_pkg::V_W-2:0] maxv;
    logic [7:0]              res;
    u    = v[pcc_pkg::V_W-2:0] >> (4'd8 - bits);
    maxv = (11'd1 << bits) - 11'd1;
    if (v[pcc_pkg::V_W-1]) begin
      res = 8'd0;
    end else if (u > maxv) begin
      res = maxv[7:0];
    end else begin
      res = u[7:0];
    end
    return res;
  endfunction

  always_comb begin
    luma = '0;
    for (int i = 0; i < pcc_pkg::NUM_LANES; i++) begin
      luma = luma + signed_val(comp_i[i].neg, pcc_pkg::MAG_W'(term_i[i]));
    end
    for (int i = 0; i < pcc_pkg::NUM_LANES; i++) begin
      val[i] = cfg_i.grayscale_on ? luma : signed_val(comp_i[i].neg, comp_i[i].mag);
      // xor on the low byte keeps the two's complement sign
      if (cfg_i.invert_on) begin
        val[i] = val[i] ^ 12'sh0FF;
      end
    end
  end

  always_comb begin
    case (cfg_i.pixel_format)
      pcc_pkg::FMT_RGB555: begin
        bits_r = 4'd5; bits_g = 4'd5; bits_b = 4'd5;
      end
      pcc_pkg::FMT_RGB565: begin
        bits_r = 4'd5; bits_g = 4'd6; bits_b = 4'd5;
      end
      default: begin
        bits_r = 4'd8; bits_g = 4'd8; bits_b = 4'd8;
      end
    endcase
    red   = reduce(val[0], bits_r);
    green = reduce(val[1], bits_g);
    blue  = reduce(val[2], bits_b);
    case (cfg_i.pixel_format)
      pcc_pkg::FMT_RGB555: pixel_d = {9'd0, red[4:0], green[4:0], blue[4:0]};
      pcc_pkg::FMT_RGB565: pixel_d = {8'd0, red[4:0], green[5:0], blue[4:0]};
      default:             pixel_d = {red, green, blue};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pixel_q <= pixel_d;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

// ----- design/palette_color_convert_core.sv -----
// Top level of the palette color converter: config registers, stall control, pipeline.
// Converts one 12-bit color RAM word per clock into a packed RGB555/565/888 pixel.
// The pipeline has seven register stages between an accepted request and a valid pixel on
// the output register: one stage for mask/mode/scale/brightness, two for the contrast
// multiply and divide by 100, three for the luma weight multiply, divide by 1000 and
// rounding, and one for gray sum, invert, clamp and packing. Throughput is one pixel per clock;
// the whole pipeline holds while a finished pixel sits stalled in the output register,
// and in_stall_o follows out_stall_i in that case. cfg_ready_o is always high; write
// registers only while no request is in flight.
module palette_color_convert_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [11:0]                     color_word_i,
  input  logic [1:0]                      mode_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [23:0]                     pixel_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcc_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  pcc_pkg::cfg_t                              cfg_q;
  pcc_pkg::cfg_t                              cfg_d;
  logic                                       en;
  logic                                       exp_valid;
  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]    exp_comp;
  logic                                       con_valid;
  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]    con_comp;
  logic                                       gry_valid;
  pcc_pkg::comp_t [pcc_pkg::NUM_LANES-1:0]    gry_comp;
  logic [pcc_pkg::NUM_LANES-1:0][pcc_pkg::Q_W-1:0] gry_term;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pcc_pkg::REG_BRIGHTNESS:   cfg_d.brightness   = cfg_data_i;
        pcc_pkg::REG_CONTRAST:     cfg_d.contrast     = cfg_data_i;
        pcc_pkg::REG_GRAYSCALE_ON: cfg_d.grayscale_on = cfg_data_i[0];
        pcc_pkg::REG_INVERT_ON:    cfg_d.invert_on    = cfg_data_i[0];
        pcc_pkg::REG_SCALE_METHOD: cfg_d.scale_method = cfg_data_i[1:0];
        pcc_pkg::REG_PIXEL_FORMAT: cfg_d.pixel_format = cfg_data_i[1:0];
        pcc_pkg::REG_FULL_PALETTE: cfg_d.full_palette = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness   <= 8'd100;
      cfg_q.contrast     <= 8'd100;
      cfg_q.grayscale_on <= 1'b0;
      cfg_q.invert_on    <= 1'b0;
      cfg_q.scale_method <= pcc_pkg::SCALE_224;
      cfg_q.pixel_format <= pcc_pkg::FMT_RGB888;
      cfg_q.full_palette <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // all stages advance together unless the output pixel is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  pcc_expand u_expand (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .color_word_i (color_word_i),
    .mode_i       (mode_i),
    .cfg_i        (cfg_q),
    .valid_o      (exp_valid),
    .comp_o       (exp_comp)
  );

  pcc_contrast u_contrast (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (exp_valid),
    .comp_i  (exp_comp),
    .cfg_i   (cfg_q),
    .valid_o (con_valid),
    .comp_o  (con_comp)
  );

  pcc_gray u_gray (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (con_valid),
    .comp_i  (con_comp),
    .valid_o (gry_valid),
    .comp_o  (gry_comp),
    .term_o  (gry_term)
  );

  pcc_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (gry_valid),
    .comp_i  (gry_comp),
    .term_i  (gry_term),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .pixel_o (pixel_o)
  );

  a_rgb555_high_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cfg_q.pixel_format == pcc_pkg::FMT_RGB555) |-> pixel_o[23:15] == '0)
    else $error("RGB555 pixel has bits set above bit 14");

  a_rgb565_high_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cfg_q.pixel_format == pcc_pkg::FMT_RGB565) |-> pixel_o[23:16] == '0)
    else $error("RGB565 pixel has bits set above bit 15");

  a_gray_equal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cfg_q.grayscale_on && (cfg_q.pixel_format == pcc_pkg::FMT_RGB888)
    |-> (pixel_o[23:16] == pixel_o[15:8]) && (pixel_o[15:8] == pixel_o[7:0]))
    else $error("gray RGB888 pixel has unequal components");

  a_stall_freezes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_o) && $stable(gry_term))
    else $error("pipeline moved while the output pixel was stalled");

endmodule
